### hdl/hdtf_pkg.sv
// hdtf_pkg: shared constants and types for the header/tail frame deframer.
// No dependencies; used by hdtf_track, hdtf_outreg and header_tail_frame_deframer.
package hdtf_pkg;

    localparam logic [7:0]  HEADER_BYTE = 8'h7E;
    localparam logic [31:0] TAIL_WORD   = 32'hFFFC_FFFF;
    // 8-bit sum of the four tail bytes
    localparam logic [7:0]  TAIL_SUM    = 8'hF9;
    localparam int unsigned MIN_FRAME   = 9;
    localparam int unsigned FUNC_OFFSET = 3;

    // configuration register indexes
    localparam logic REG_MAX_FRAME_LEN = 1'b0;
    localparam logic REG_COMMAND_ID    = 1'b1;

    typedef struct packed {
        logic checksum_ok;
        logic command_ok;
        logic too_short;
        logic overflowed;
    } flags_t;

endpackage

### hdl/hdtf_track.sv
// hdtf_track: per-frame state (count, tail window, running sum, function byte)
// and end-of-frame status. Depends on hdtf_pkg.
module hdtf_track #(
    parameter int LEN_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_in,
    input  logic [LEN_BITS-1:0] max_len,
    input  logic [7:0]          cmd_id,
    output logic                hit,
    output logic [LEN_BITS-1:0] res_len,
    output hdtf_pkg::flags_t    res_flags,
    output logic                hunting
);

    logic [LEN_BITS-1:0] cnt_reg, cnt_next;
    logic [31:0]         win_reg, win_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          fb_reg, fb_next;
    logic                ovf_reg, ovf_next;

    logic [LEN_BITS-1:0] limit;
    logic [7:0]          prior;
    logic [7:0]          calc;
    logic                drop;
    logic                shortf;

    always_comb
    begin
        limit    = (max_len == '0) ? LEN_BITS'(1) : max_len;
        drop     = (cnt_reg == '0) && (byte_in != hdtf_pkg::HEADER_BYTE);
        cnt_next = cnt_reg;
        fb_next  = fb_reg;
        ovf_next = ovf_reg;
        sum_next = sum_reg;
        if (cnt_reg < limit)
        begin
            if (cnt_reg == LEN_BITS'(hdtf_pkg::FUNC_OFFSET))
            begin
                fb_next = byte_in;
            end
            cnt_next = cnt_reg + LEN_BITS'(1);
        end
        else
        begin
            ovf_next = 1'b1;
        end
        if (cnt_reg >= LEN_BITS'(hdtf_pkg::FUNC_OFFSET))
        begin
            sum_next = sum_reg + byte_in;
        end
        prior    = win_reg[31:24];
        win_next = {win_reg[23:0], byte_in};

        hit    = step && !drop && (win_next == hdtf_pkg::TAIL_WORD);
        shortf = cnt_next < LEN_BITS'(hdtf_pkg::MIN_FRAME);
        // checksum byte sits just ahead of the tail; strip it and the tail from the sum
        calc   = sum_next - prior - hdtf_pkg::TAIL_SUM;

        res_len               = cnt_next;
        res_flags.too_short   = shortf;
        res_flags.overflowed  = ovf_next;
        res_flags.checksum_ok = !shortf && !ovf_next && (calc == prior);
        res_flags.command_ok  = !shortf && (fb_next == cmd_id);
    end

    assign hunting = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            win_reg <= '0;
            sum_reg <= '0;
            fb_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else if (step && !drop)
        begin
            if (hit)
            begin
                cnt_reg <= '0;
                win_reg <= '0;
                sum_reg <= '0;
                fb_reg  <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                win_reg <= win_next;
                sum_reg <= sum_next;
                fb_reg  <= fb_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

### hdl/hdtf_outreg.sv
// hdtf_outreg: result register for the status transfer, held while stalled.
// Depends on hdtf_pkg.
module hdtf_outreg #(
    parameter int LEN_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [LEN_BITS-1:0] load_len,
    input  hdtf_pkg::flags_t    load_flags,
    input  logic                stall,
    output logic                ready,
    output logic                valid,
    output logic [LEN_BITS-1:0] len,
    output hdtf_pkg::flags_t    flags
);

    logic                valid_reg;
    logic [LEN_BITS-1:0] len_reg;
    hdtf_pkg::flags_t    flags_reg;

    assign ready = !valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            len_reg   <= load_len;
            flags_reg <= load_flags;
        end
    end

    assign valid = valid_reg;
    assign len   = len_reg;
    assign flags = flags_reg;

endmodule

### hdl/header_tail_frame_deframer.sv
// Header/tail byte-stream deframer with 8-bit additive checksum check.
// Throughput: one byte per cycle unless a held result blocks the input; a byte is registered, then processed.
// The tail byte passes the input register, then its status loads the result register and out_valid rises.
// Input stalls only while the input register is full and the result register is held.
// Reset (async, active low) returns to hunting, clears frame state, loads register defaults.
// Depends on hdtf_pkg, hdtf_track, hdtf_outreg.
module header_tail_frame_deframer #(
    parameter int LEN_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [LEN_BITS-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LEN_BITS-1:0] frame_length,
    output logic                checksum_ok,
    output logic                command_ok,
    output logic                too_short,
    output logic                overflowed
);

    localparam int KEEP_BITS = (LEN_BITS < 12) ? LEN_BITS : 12;
    localparam logic [LEN_BITS-1:0] LEN_MASK = LEN_BITS'((1 << KEEP_BITS) - 1);
    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(1500);

    logic [LEN_BITS-1:0] max_len_reg;
    logic [7:0]          cmd_id_reg;
    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;

    logic                out_ready;
    logic                accept;
    logic                step;
    logic                hit;
    logic                hunting;
    logic [LEN_BITS-1:0] res_len;
    hdtf_pkg::flags_t    res_flags;
    hdtf_pkg::flags_t    out_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LEN_RESET & LEN_MASK;
            cmd_id_reg  <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hdtf_pkg::REG_MAX_FRAME_LEN: max_len_reg <= cfg_data & LEN_MASK;
                hdtf_pkg::REG_COMMAND_ID:    cmd_id_reg  <= cfg_data[7:0];
                default:                     cmd_id_reg  <= cmd_id_reg;
            endcase
        end
    end

    // input register stage
    assign step     = s1_valid_reg && out_ready;
    assign in_stall = s1_valid_reg && !out_ready;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    hdtf_track #(
        .LEN_BITS (LEN_BITS)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (s1_byte_reg),
        .max_len   (max_len_reg),
        .cmd_id    (cmd_id_reg),
        .hit       (hit),
        .res_len   (res_len),
        .res_flags (res_flags),
        .hunting   (hunting)
    );

    hdtf_outreg #(
        .LEN_BITS (LEN_BITS)
    ) u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (hit),
        .load_len   (res_len),
        .load_flags (res_flags),
        .stall      (out_stall),
        .ready      (out_ready),
        .valid      (out_valid),
        .len        (frame_length),
        .flags      (out_flags)
    );

    assign checksum_ok = out_flags.checksum_ok;
    assign command_ok  = out_flags.command_ok;
    assign too_short   = out_flags.too_short;
    assign overflowed  = out_flags.overflowed;

    // input side only backs up when a result is being held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // a short frame never reports a good checksum or command
    a_short_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_short) |-> (!checksum_ok && !command_ok))
        else $error("short frame with checksum_ok or command_ok set");

    a_ovf_cks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflowed) |-> !checksum_ok)
        else $error("overflowed frame with checksum_ok set");

    // frame state is cleared after the tail is seen
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> hunting)
        else $error("frame state not cleared after tail");

endmodule

### bench/tb_header_tail_frame_deframer.sv
// Testbench for header_tail_frame_deframer: byte stream in, one status transfer per frame out.
// A scoreboard class predicts each status from the accepted bytes; plain tasks drive the ports.
// Depends on hdtf_pkg and the RTL of header_tail_frame_deframer only.
module tb_header_tail_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] bytes_t[$];

    typedef struct {
        logic [11:0] frame_length;
        logic        checksum_ok;
        logic        command_ok;
        logic        too_short;
        logic        overflowed;
    } status_t;

    class frame_scoreboard;
        logic [11:0] max_len;
        logic [7:0]  cmd_id;
        logic [11:0] count;
        logic [31:0] window;
        logic [7:0]  sum;
        logic [7:0]  func;
        bit          ovf_seen;
        status_t     pending[$];
        int          errors;
        int          checked;
        int          accepted;
        int          shorts;
        int          overflows;

        function new();
            max_len = 12'd1500;
            cmd_id  = 8'd1;
            clear_frame();
        endfunction

        function void clear_frame();
            count    = '0;
            window   = '0;
            sum      = '0;
            func     = '0;
            ovf_seen = 1'b0;
        endfunction

        function void write_reg(logic idx, logic [11:0] val);
            if (idx == hdtf_pkg::REG_MAX_FRAME_LEN)
                max_len = val;
            else
                cmd_id = val[7:0];
        endfunction

        function void note_byte(logic [7:0] b);
            logic [11:0] lim;
            logic [11:0] pos;
            logic [7:0]  prior;
            logic [7:0]  calc;
            status_t     s;
            accepted++;
            lim = (max_len == 0) ? 12'd1 : max_len;
            pos = count;
            if (pos == 0 && b != hdtf_pkg::HEADER_BYTE)
                return;
            if (pos < lim)
            begin
                if (pos == hdtf_pkg::FUNC_OFFSET)
                    func = b;
                count = pos + 12'd1;
            end
            else
                ovf_seen = 1'b1;
            if (pos >= hdtf_pkg::FUNC_OFFSET)
                sum = sum + b;
            prior  = window[31:24];
            window = {window[23:0], b};
            if (window != hdtf_pkg::TAIL_WORD)
                return;
            // checksum byte sits just ahead of the tail; strip it and the tail from the sum
            calc = sum - prior - hdtf_pkg::TAIL_SUM;
            s.frame_length = count;
            s.too_short    = count < hdtf_pkg::MIN_FRAME;
            s.overflowed   = ovf_seen;
            s.checksum_ok  = !s.too_short && !ovf_seen && calc == prior;
            s.command_ok   = !s.too_short && func == cmd_id;
            shorts    += int'(s.too_short);
            overflows += int'(s.overflowed);
            pending.push_back(s);
            clear_frame();
        endfunction

        function void cmp(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: mismatch on %s, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(status_t got);
            status_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: status transfer with none expected, expected none, %s %0d",
                         $time, "actual length", got.frame_length);
                return;
            end
            want = pending.pop_front();
            checked++;
            cmp("frame_length", want.frame_length, got.frame_length);
            cmp("checksum_ok", 12'(want.checksum_ok), 12'(got.checksum_ok));
            cmp("command_ok", 12'(want.command_ok), 12'(got.command_ok));
            cmp("too_short", 12'(want.too_short), 12'(got.too_short));
            cmp("overflowed", 12'(want.overflowed), 12'(got.overflowed));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] frame_length;
    logic        checksum_ok;
    logic        command_ok;
    logic        too_short;
    logic        overflowed;

    frame_scoreboard scb = new();
    int send_pct = 18;
    int recv_pct = 49;
    bit calm = 1'b0;

    header_tail_frame_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_length (frame_length),
        .checksum_ok  (checksum_ok),
        .command_ok   (command_ok),
        .too_short    (too_short),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // status receiver: check on transfer, then pick the next stall
    initial
    begin : status_sink
        status_t got;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.frame_length = frame_length;
                got.checksum_ok  = checksum_ok;
                got.command_ok   = command_ok;
                got.too_short    = too_short;
                got.overflowed   = overflowed;
                scb.check_result(got);
            end
            out_stall <= !calm && ($urandom_range(99) < recv_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        scb.note_byte(b);
    endtask

    task automatic send_seq(input bytes_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    // well-formed frame of len bytes; under 9 bytes it is header, filler and tail
    task automatic send_frame(input int len, input bit good_cks, input bit good_cmd);
        bytes_t     q;
        logic [7:0] fsum;
        q.push_back(hdtf_pkg::HEADER_BYTE);
        if (len >= hdtf_pkg::MIN_FRAME)
        begin
            q.push_back(8'($urandom));
            q.push_back(8'($urandom));
            q.push_back(good_cmd ? scb.cmd_id : 8'($urandom));
            fsum = q[3];
            for (int i = 4; i <= len - 6; i++)
            begin
                q.push_back(8'($urandom));
                fsum = fsum + q[i];
            end
            q.push_back(good_cks ? fsum : 8'(fsum + $urandom_range(255, 1)));
        end
        else
            for (int i = 1; i <= len - 5; i++)
                q.push_back(8'($urandom));
        q.push_back(8'hFF);
        q.push_back(8'hFC);
        q.push_back(8'hFF);
        q.push_back(8'hFF);
        send_seq(q);
    endtask

    // sender holds off until every status is in, then lets the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (scb.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_regs(input logic [11:0] len_val, input logic [11:0] cmd_val);
        cfg_we    <= 1'b1;
        cfg_index <= hdtf_pkg::REG_MAX_FRAME_LEN;
        cfg_data  <= len_val;
        @(posedge clk);
        scb.write_reg(hdtf_pkg::REG_MAX_FRAME_LEN, len_val);
        cfg_index <= hdtf_pkg::REG_COMMAND_ID;
        cfg_data  <= cmd_val;
        @(posedge clk);
        scb.write_reg(hdtf_pkg::REG_COMMAND_ID, cmd_val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          lim_tab[6];
        int          frame_bytes;
        int          r;
        int          len;
        logic [11:0] cmd_val;
        bytes_t      q;

        lim_tab   = '{1500, 9, 4095, 0, 3, 200};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values: noise, good frame, shortest frame, bad frame
        q = '{8'h00, 8'hFF,
              8'h7E, 8'h11, 8'h22, 8'h01, 8'h01, 8'hFF, 8'hFC, 8'hFF, 8'hFF,
              8'h7E, 8'hFF, 8'hFC, 8'hFF, 8'hFF,
              8'h7E, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hFF, 8'hFC, 8'hFF, 8'hFF};
        send_seq(q);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            send_pct = (ph < 2) ? 18 : (ph < 4) ? 49 : 0;
            recv_pct = (ph < 2) ? 49 : (ph < 4) ? 18 : 0;
            case (ph)
                1:       cmd_val = 12'h000;
                2:       cmd_val = 12'hFFF;
                default: cmd_val = 12'($urandom_range(4095));
            endcase
            write_regs(12'(lim_tab[ph]), cmd_val);
            frame_bytes = 0;
            while (frame_bytes < 265)
            begin
                calm = ($urandom_range(3) == 0);
                r = $urandom_range(99);
                if (r < 75)
                begin
                    r = $urandom_range(99);
                    len = (r < 10) ? $urandom_range(8, 5) :
                          (r < 88) ? $urandom_range(40, 9) : $urandom_range(260, 41);
                    send_frame(len, $urandom_range(3) != 0, $urandom_range(9) < 7);
                    frame_bytes += len;
                end
                else if (r < 90)
                begin
                    // line noise; it may fall inside a frame left open
                    repeat ($urandom_range(6, 1))
                        send_byte(8'($urandom));
                end
                else
                begin
                    // header with no tail; the next tail closes it
                    len = $urandom_range(10, 1);
                    send_byte(hdtf_pkg::HEADER_BYTE);
                    repeat (len)
                        send_byte(8'($urandom));
                    frame_bytes += len + 1;
                end
            end
        end

        calm = 1'b1;
        drain();
        repeat (10) @(posedge clk);
        $display("Run covered %0d byte transfers and %0d status transfers over 7 settings",
                 scb.accepted, scb.checked);
        $display("of which %0d short frames and %0d overflowed frames; %0d errors",
                 scb.shorts, scb.overflows, scb.errors);
        if (scb.errors == 0 && scb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
